### sv/lla_pkg.sv
// types, constants and state codes shared by the least-loaded row assignment block
package lla_pkg;

    localparam int ITEM_W      = 12;
    localparam int ROW_INDEX_W = 4;
    localparam int ROW_W       = 16;
    localparam int ROW_COUNT_W = 5;
    localparam int PAD_W       = 9;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 9;
    localparam int SUM_W       = ROW_W + 2;

    localparam logic [ROW_W-1:0] WIDTH_LIMIT = 16'hFFFF;

    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_COUNT = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAD_WIDTH = 4'd1;

    typedef struct packed {
        logic [ITEM_W-1:0] item_width;
        logic              last_item;
    } lla_in_t;

    typedef struct packed {
        logic [ROW_INDEX_W-1:0] row_index;
        logic [ROW_W-1:0]       widest_row;
        logic                   run_done;
        logic                   width_overflow;
    } lla_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MIN_SCAN,
        ST_UPDATE,
        ST_MAX_SCAN,
        ST_DONE
    } lla_state_t;

endpackage

### sv/lla_stream_if.sv
// valid/ready word channel with source and sink views
interface lla_stream_if #(
    parameter type data_t = logic
);
    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### sv/least_loaded_row_assignment_top.sv
// least-loaded row assignment: greedy placement of items into rows with one shared comparator
//
//  channel  | dir | word                                            | handshake
//  in_ch    | in  | item_width, last_item                           | valid/ready
//  out_ch   | out | row_index, widest_row, run_done, width_overflow | valid/ready
//  cfg      | in  | cfg_index, cfg_data                             | cfg_we, no stall
//
// each word scans the rows in use for the narrowest row, and the last word of a run also for the widest;
// the scan reads one row width from the row memory and compares it per cycle
// reset clears control state; row widths are marked stale at the first word of a run
// and read back as the padding latched then, so no clearing pass is needed
// in_ch.ready is high only while idle; a result waits in out_ch until taken
module least_loaded_row_assignment_top #(
    parameter int MAX_ROWS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    lla_stream_if.sink                       in_ch,
    lla_stream_if.source                     out_ch,
    input  logic                             cfg_we,
    input  logic [lla_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [lla_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import lla_pkg::*;

    localparam int IDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CNT_W = $clog2(MAX_ROWS + 1);

    lla_state_t state_reg, state_next;

    logic [ROW_COUNT_W-1:0] row_count_reg;
    logic [PAD_W-1:0]       pad_width_reg;
    logic                   in_run_reg;
    logic                   ovf_reg;
    logic [ITEM_W-1:0]      width_reg;
    logic                   last_reg;
    logic [PAD_W-1:0]       run_pad_reg;
    logic [CNT_W-1:0]       n_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   rd_live_reg;
    logic [IDX_W-1:0]       rd_idx_reg;
    logic [ROW_W-1:0]       rd_data_reg;
    logic                   rd_vbit_reg;
    logic [ROW_W-1:0]       best_val_reg;
    logic [IDX_W-1:0]       best_idx_reg;
    logic [IDX_W-1:0]       row_sel_reg;
    logic [MAX_ROWS-1:0]    valid_reg;

    logic [ROW_W-1:0] row_mem [MAX_ROWS];

    logic             in_accept;
    logic             out_accept;
    logic             issue;
    logic             scan_min;
    logic             mem_we;
    logic [31:0]      n32;
    logic [ROW_W-1:0] rd_val;
    logic [ROW_W-1:0] cmp_a;
    logic [ROW_W-1:0] cmp_b;
    logic             take;
    logic [SUM_W-1:0] sum;
    logic [ROW_W-1:0] sat_sum;
    logic             sum_ovf;

    assign in_accept  = in_ch.valid & in_ch.ready;
    assign out_accept = out_ch.valid & out_ch.ready;

    // rows in use, clamped to one .. MAX_ROWS
    always_comb
    begin
        n32 = {{(32-ROW_COUNT_W){1'b0}}, row_count_reg};
        if (n32 == 32'd0)
        begin
            n32 = 32'd1;
        end
        else if (n32 > 32'(MAX_ROWS))
        begin
            n32 = 32'(MAX_ROWS);
        end
    end

    // shared compare unit: min scan looks for smaller, max scan for larger
    assign rd_val   = rd_vbit_reg ? rd_data_reg : {{(ROW_W-PAD_W){1'b0}}, run_pad_reg};
    assign cmp_a    = scan_min ? rd_val : best_val_reg;
    assign cmp_b    = scan_min ? best_val_reg : rd_val;
    assign take     = (rd_idx_reg == '0) || (cmp_a < cmp_b);

    assign sum      = {2'b00, best_val_reg}
                    + {{(SUM_W-ITEM_W){1'b0}}, width_reg}
                    + {{(SUM_W-PAD_W){1'b0}}, pad_width_reg};
    assign sum_ovf  = (sum[SUM_W-1:ROW_W] != '0);
    assign sat_sum  = sum_ovf ? WIDTH_LIMIT : sum[ROW_W-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_MIN_SCAN;
                end
            end
            ST_MIN_SCAN:
            begin
                if (cnt_reg == n_reg)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = last_reg ? ST_MAX_SCAN : ST_DONE;
            end
            ST_MAX_SCAN:
            begin
                if (cnt_reg == n_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_accept)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        in_ch.ready  = 1'b0;
        out_ch.valid = 1'b0;
        issue        = 1'b0;
        scan_min     = 1'b0;
        mem_we       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ch.ready = 1'b1;
            end
            ST_MIN_SCAN:
            begin
                scan_min = 1'b1;
                issue    = (cnt_reg < n_reg);
            end
            ST_UPDATE:
            begin
                mem_we = 1'b1;
            end
            ST_MAX_SCAN:
            begin
                issue = (cnt_reg < n_reg);
            end
            ST_DONE:
            begin
                out_ch.valid = 1'b1;
            end
            default:
            begin
                in_ch.ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_ch.data.row_index      = ROW_INDEX_W'(row_sel_reg);
        out_ch.data.widest_row     = last_reg ? best_val_reg : '0;
        out_ch.data.run_done       = last_reg;
        out_ch.data.width_overflow = ovf_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= ROW_COUNT_W'(1);
            pad_width_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_ROW_COUNT)
            begin
                row_count_reg <= cfg_data[ROW_COUNT_W-1:0];
            end
            else if (cfg_index == CFG_PAD_WIDTH)
            begin
                pad_width_reg <= cfg_data[PAD_W-1:0];
            end
        end
    end

    // run control and row valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_run_reg  <= 1'b0;
            ovf_reg     <= 1'b0;
            valid_reg   <= '0;
            rd_live_reg <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            if (in_accept && !in_run_reg)
            begin
                in_run_reg <= 1'b1;
                valid_reg  <= '0;
            end
            if (in_accept || mem_we)
            begin
                cnt_reg     <= '0;
                rd_live_reg <= 1'b0;
            end
            else
            begin
                cnt_reg     <= cnt_reg + CNT_W'(issue);
                rd_live_reg <= issue;
            end
            if (mem_we)
            begin
                valid_reg[best_idx_reg] <= 1'b1;
                if (sum_ovf)
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (out_accept && last_reg)
            begin
                in_run_reg <= 1'b0;
                ovf_reg    <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            width_reg <= in_ch.data.item_width;
            last_reg  <= in_ch.data.last_item;
            n_reg     <= n32[CNT_W-1:0];
            if (!in_run_reg)
            begin
                run_pad_reg <= pad_width_reg;
            end
        end
        rd_idx_reg <= cnt_reg[IDX_W-1:0];
        if (rd_live_reg && take)
        begin
            best_val_reg <= rd_val;
            best_idx_reg <= rd_idx_reg;
        end
        if (mem_we)
        begin
            row_sel_reg <= best_idx_reg;
        end
    end

    // row width memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            row_mem[best_idx_reg] <= sat_sum;
        end
        rd_data_reg <= row_mem[cnt_reg[IDX_W-1:0]];
        rd_vbit_reg <= valid_reg[cnt_reg[IDX_W-1:0]];
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !in_ch.ready)
        else $error("result offered while taking input");

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (CNT_W'(row_sel_reg) < n_reg))
        else $error("row index outside rows in use");

    a_run_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_accept && last_reg) |=> (!in_run_reg && !ovf_reg))
        else $error("run not closed after last word");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MIN_SCAN || state_reg == ST_MAX_SCAN) |-> (cnt_reg <= n_reg))
        else $error("scan counter past rows in use");

    a_in_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> in_run_reg)
        else $error("run not open after accepted word");

endmodule

### dv/least_loaded_row_assignment_top_test.sv
`timescale 1ns / 1ps
// self-checking testbench for the least-loaded row assignment block, directed and random runs
module least_loaded_row_assignment_top_test;
    import lla_pkg::*;

    localparam int ROW_SLOTS     = 16;
    localparam int RANDOM_WORDS  = 1150;
    localparam int QUIET_TAIL    = 150;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 2 * ROW_SLOTS + 8;
    localparam int PRINT_CAP     = 40;

    class row_load_scoreboard;
        logic [ROW_COUNT_W-1:0] row_count;
        logic [PAD_W-1:0]       pad_width;
        logic [ROW_W-1:0]       row_width [ROW_SLOTS];
        bit                     overflow_seen;
        bit                     run_open;
        lla_out_t               expected_q [$];
        int                     errors;
        int                     checked;
        int                     runs_closed;
        int                     saturated_runs;

        function new();
            row_count      = ROW_COUNT_W'(1);
            pad_width      = '0;
            overflow_seen  = 1'b0;
            run_open       = 1'b0;
            errors         = 0;
            checked        = 0;
            runs_closed    = 0;
            saturated_runs = 0;
            foreach (row_width[i])
            begin
                row_width[i] = '0;
            end
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
            if (index == CFG_ROW_COUNT)
            begin
                row_count = value[ROW_COUNT_W-1:0];
            end
            else if (index == CFG_PAD_WIDTH)
            begin
                pad_width = value[PAD_W-1:0];
            end
        endfunction

        function void note_item(lla_in_t word);
            int unsigned    rows;
            int unsigned    best;
            int unsigned    sum;
            logic [ROW_W-1:0] widest;
            lla_out_t       res;
            rows = (row_count == '0) ? 1
                 : ((int'(row_count) > ROW_SLOTS) ? ROW_SLOTS : int'(row_count));
            if (!run_open)
            begin
                foreach (row_width[i])
                begin
                    row_width[i] = ROW_W'(pad_width);
                end
                run_open = 1'b1;
            end
            best = 0;
            for (int i = 1; i < rows; i++)
            begin
                if (row_width[i] < row_width[best])
                begin
                    best = i;
                end
            end
            sum = row_width[best] + word.item_width + pad_width;
            if (sum > WIDTH_LIMIT)
            begin
                sum = {16'h0000, WIDTH_LIMIT};
                overflow_seen = 1'b1;
            end
            row_width[best] = ROW_W'(sum);
            widest = '0;
            if (word.last_item)
            begin
                for (int i = 0; i < rows; i++)
                begin
                    if (row_width[i] > widest)
                    begin
                        widest = row_width[i];
                    end
                end
            end
            res.row_index      = ROW_INDEX_W'(best);
            res.widest_row     = widest;
            res.run_done       = word.last_item;
            res.width_overflow = overflow_seen;
            expected_q = {expected_q, res};
            if (word.last_item)
            begin
                runs_closed++;
                if (overflow_seen)
                begin
                    saturated_runs++;
                end
                run_open      = 1'b0;
                overflow_seen = 1'b0;
            end
        endfunction

        task report_mismatch(string what);
            errors++;
            if (errors <= PRINT_CAP)
            begin
                $display("mismatch: %s", what);
            end
        endtask

        task check_result(lla_out_t got);
            lla_out_t want;
            if (expected_q.size() == 0)
            begin
                report_mismatch($sformatf("word with nothing expected, row %0d", got.row_index));
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.row_index !== want.row_index)
            begin
                report_mismatch($sformatf("result %0d row_index %0d, expected %0d",
                                          checked, got.row_index, want.row_index));
            end
            if (got.widest_row !== want.widest_row)
            begin
                report_mismatch($sformatf("result %0d widest_row %0d, expected %0d",
                                          checked, got.widest_row, want.widest_row));
            end
            if (got.run_done !== want.run_done)
            begin
                report_mismatch($sformatf("result %0d run_done %0b, expected %0b",
                                          checked, got.run_done, want.run_done));
            end
            if (got.width_overflow !== want.width_overflow)
            begin
                report_mismatch($sformatf("result %0d width_overflow %0b, expected %0b",
                                          checked, got.width_overflow, want.width_overflow));
            end
        endtask
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    lla_stream_if #(.data_t(lla_in_t))  in_ch ();
    lla_stream_if #(.data_t(lla_out_t)) out_ch ();

    row_load_scoreboard sb = new();

    bit idling_on;
    int words_sent;
    int run_left;
    int cycles = 0;

    least_loaded_row_assignment_top #(
        .MAX_ROWS (ROW_SLOTS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
        end
        $display("timeout after %0d cycles", cycles);
        $display("least_loaded_row_assignment_top_test failed");
        $finish;
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(index, value);
        @(posedge clk);
    endtask

    task automatic send_word(input logic [ITEM_W-1:0] width, input logic last);
        int      gap;
        lla_in_t word;
        word.item_width = width;
        word.last_item  = last;
        gap = (idling_on && $urandom_range(0, 4) < 2) ? $urandom_range(1, 11) : 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= word;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_item(word);
        words_sent++;
    endtask

    task automatic drain();
        int waited;
        waited = 0;
        in_ch.valid <= 1'b0;
        while (sb.expected_q.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (sb.expected_q.size() != 0)
        begin
            sb.report_mismatch($sformatf("%0d results never arrived", sb.expected_q.size()));
            sb.expected_q.delete();
        end
    endtask

    task automatic configure_random(input bit heavy);
        int                    pick;
        logic [CFG_DATA_W-1:0] value;
        if (heavy || $urandom_range(0, 4) != 0)
        begin
            pick  = $urandom_range(0, 9);
            value = CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1));
            if (heavy)
                value[ROW_COUNT_W-1:0] = ROW_COUNT_W'($urandom_range(1, 2));
            else if (pick == 0)
                value[ROW_COUNT_W-1:0] = '0;
            else if (pick == 1)
                value[ROW_COUNT_W-1:0] = ROW_COUNT_W'(ROW_SLOTS);
            else if (pick == 2)
                value[ROW_COUNT_W-1:0] = ROW_COUNT_W'(1);
            else if (pick == 3)
                value[ROW_COUNT_W-1:0] = ROW_COUNT_W'($urandom_range(ROW_SLOTS + 1,
                                                                     (1 << ROW_COUNT_W) - 1));
            else
                value[ROW_COUNT_W-1:0] = ROW_COUNT_W'($urandom_range(2, ROW_SLOTS - 1));
            write_reg(CFG_ROW_COUNT, value);
        end
        if ($urandom_range(0, 4) != 0)
        begin
            pick = $urandom_range(0, 5);
            if (pick == 0)
                value = '0;
            else if (pick == 1)
                value = CFG_DATA_W'((1 << PAD_W) - 1);
            else
                value = CFG_DATA_W'($urandom_range(0, (1 << PAD_W) - 1));
            write_reg(CFG_PAD_WIDTH, value);
        end
        if ($urandom_range(0, 9) == 0)
        begin
            write_reg(CFG_INDEX_W'($urandom_range(int'(CFG_PAD_WIDTH) + 1, (1 << CFG_INDEX_W) - 1)),
                      CFG_DATA_W'($urandom));
        end
    endtask

    task automatic send_runs(input int count, input bit heavy);
        int                pick;
        logic [ITEM_W-1:0] width;
        repeat (count)
        begin
            if (run_left == 0)
            begin
                pick = $urandom_range(0, 9);
                if (heavy)
                    run_left = $urandom_range(30, 48);
                else if (pick < 6)
                    run_left = $urandom_range(1, 12);
                else if (pick < 9)
                    run_left = $urandom_range(13, 48);
                else
                    run_left = 1;
            end
            pick = $urandom_range(0, 9);
            if (heavy)
                width = ITEM_W'($urandom_range(3584, 4095));
            else if (pick == 0)
                width = '0;
            else if (pick == 1)
                width = '1;
            else if (pick < 4)
                width = ITEM_W'($urandom_range(0, 63));
            else
                width = ITEM_W'($urandom_range(0, (1 << ITEM_W) - 1));
            run_left--;
            send_word(width, run_left == 0);
        end
    endtask

    initial
    begin
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (idling_on && $urandom_range(0, 4) < 2)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_ch.valid);
            sb.check_result(out_ch.data);
        end
    end

    initial
    begin
        int target;
        int chunk;
        bit heavy;
        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;
        idling_on   = 1'b1;
        words_sent  = 0;
        run_left    = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: one row, no padding
        send_word('0, 1'b0);
        send_word('1, 1'b1);
        drain();

        // all rows, widest padding, tie-breaking from equal rows
        write_reg(CFG_ROW_COUNT, CFG_DATA_W'(ROW_SLOTS));
        write_reg(CFG_PAD_WIDTH, CFG_DATA_W'((1 << PAD_W) - 1));
        write_reg(CFG_INDEX_W'(int'(CFG_PAD_WIDTH) + 1), '1);
        write_reg('1, '0);
        send_word('0, 1'b0);
        send_word('1, 1'b0);
        send_word('0, 1'b0);
        send_word('1, 1'b1);
        drain();

        // zero row count acts as one row, drive that row into saturation
        write_reg(CFG_ROW_COUNT, '0);
        repeat (15) send_word('1, 1'b0);
        send_word('0, 1'b1);
        drain();

        // oversized row count clamps
        write_reg(CFG_ROW_COUNT, CFG_DATA_W'((1 << ROW_COUNT_W) - 1));
        write_reg(CFG_PAD_WIDTH, '0);
        send_word(ITEM_W'(1), 1'b0);
        send_word(ITEM_W'(2), 1'b0);
        send_word(ITEM_W'(3), 1'b1);
        drain();

        target = words_sent + RANDOM_WORDS;
        while (words_sent < target)
        begin
            heavy = ($urandom_range(0, 5) == 0);
            configure_random(heavy);
            idling_on = (words_sent < target - QUIET_TAIL) && ($urandom_range(0, 4) != 0);
            chunk = $urandom_range(5, 60);
            if (chunk > target - words_sent)
            begin
                chunk = target - words_sent;
            end
            send_runs(chunk, heavy);
            drain();
        end
        idling_on = 1'b0;
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("sent %0d words, checked %0d results over %0d closed runs",
                 words_sent, sb.checked, sb.runs_closed);
        $display("%0d runs saturated a row, %0d mismatches", sb.saturated_runs, sb.errors);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
        begin
            $display("least_loaded_row_assignment_top_test passed");
        end
        else
        begin
            $display("least_loaded_row_assignment_top_test failed");
        end
        $finish;
    end

endmodule

### sim.f
sv/lla_pkg.sv
sv/lla_stream_if.sv
sv/least_loaded_row_assignment_top.sv
dv/least_loaded_row_assignment_top_test.sv
